@@ rtl/core/ilist_pkg.sv @@
// shared types and constants for the indexed insert/erase list
package ilist_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W = 3;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int CNT_W = 5;
    localparam int ST_W  = 2;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // apply the captured command and load the result
    } ctrl_t;

endpackage

@@ rtl/core/ilist_ctrl.sv @@
// controller: handshake sequencing and output valid
module ilist_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output ilist_pkg::ctrl_t ctrl
);
    import ilist_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctrl.load      = 1'b0;
        ctrl.exec      = 1'b0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            FSM_IDLE:
            begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                // result slot free or being emptied this cycle
                if (!out_valid_reg || m_tready)
                begin
                    ctrl.exec      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/core/ilist_dp.sv @@
// datapath: shifting cell chain, entry count and result registers
module ilist_dp #(
    parameter int CAPACITY = ilist_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ilist_pkg::ctrl_t           ctrl,
    input  logic [ilist_pkg::CMD_W-1:0] command,
    input  logic [ilist_pkg::POS_W-1:0] position,
    input  logic [ilist_pkg::VAL_W-1:0] value,
    output logic [ilist_pkg::VAL_W-1:0] read_value,
    output logic [ilist_pkg::CNT_W-1:0] count,
    output logic [ilist_pkg::ST_W-1:0]  status
);
    import ilist_pkg::*;

    localparam int HW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = (HW > POS_W) ? HW : POS_W;

    logic [CMD_W-1:0] cmd_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;

    logic [VAL_W-1:0] cells_reg  [CAPACITY];
    logic [VAL_W-1:0] cells_next [CAPACITY];
    logic [HW-1:0]    held_reg;
    logic [HW-1:0]    held_next;

    logic [VAL_W-1:0] rd_reg;
    logic [VAL_W-1:0] rd_next;
    status_t          st_reg;
    status_t          st_next;

    logic [CW-1:0] pos_ext;
    logic [CW-1:0] held_ext;
    logic          full;
    logic          empty;
    logic          pos_in;     // position below held
    logic          pos_le;     // position not above held
    logic          do_push;
    logic          do_insert;
    logic          do_erase;

    assign pos_ext  = CW'(pos_reg);
    assign held_ext = CW'(held_reg);
    assign full     = held_ext >= CW'(CAPACITY);
    assign empty    = (held_reg == '0);
    assign pos_in   = pos_ext < held_ext;
    assign pos_le   = pos_ext <= held_ext;

    always_comb
    begin
        held_next = held_reg;
        rd_next   = '0;
        st_next   = ST_OK;
        do_push   = 1'b0;
        do_insert = 1'b0;
        do_erase  = 1'b0;
        case (cmd_reg)
            CMD_PUSH:
            begin
                if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    do_push   = 1'b1;
                    held_next = held_reg + HW'(1);
                end
            end
            CMD_POP:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    held_next = held_reg - HW'(1);
                end
            end
            CMD_INSERT:
            begin
                priority if (full)
                begin
                    st_next = ST_FULL;
                end
                else if (!pos_le)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    do_insert = 1'b1;
                    held_next = held_reg + HW'(1);
                end
            end
            CMD_ERASE:
            begin
                if (!pos_in)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    do_erase  = 1'b1;
                    held_next = held_reg - HW'(1);
                end
            end
            CMD_READ:
            begin
                if (!pos_in)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    rd_next = cells_reg[pos_ext[IW-1:0]];
                end
            end
            CMD_CLEAR:
            begin
                held_next = '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    // each cell picks hold, its lower neighbor, its upper neighbor or the new word
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [VAL_W-1:0] from_below;
        logic [VAL_W-1:0] from_above;
        logic [CW-1:0]    kk;

        assign kk = CW'(k);

        if (k > 0)
        begin : g_below
            assign from_below = cells_reg[k-1];
        end
        else
        begin : g_no_below
            assign from_below = cells_reg[k];
        end

        if (k < CAPACITY - 1)
        begin : g_above
            assign from_above = cells_reg[k+1];
        end
        else
        begin : g_no_above
            assign from_above = cells_reg[k];
        end

        always_comb
        begin
            cells_next[k] = cells_reg[k];
            priority if (do_push && kk == held_ext)
            begin
                cells_next[k] = val_reg;
            end
            else if (do_insert && kk == pos_ext)
            begin
                cells_next[k] = val_reg;
            end
            else if (do_insert && kk > pos_ext && kk <= held_ext)
            begin
                cells_next[k] = from_below;
            end
            else if (do_erase && kk >= pos_ext && (kk + CW'(1)) < held_ext)
            begin
                cells_next[k] = from_above;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= command;
            pos_reg <= position;
            val_reg <= value;
        end
        if (ctrl.exec)
        begin
            cells_reg <= cells_next;
            rd_reg    <= rd_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            held_reg <= held_next;
        end
    end

    assign read_value = rd_reg;
    assign count      = CNT_W'(held_reg);
    assign status     = st_reg;

endmodule

@@ rtl/core/indexed_insert_erase_list.sv @@
// sequencing: a beat is captured in the idle state and its result is registered in the
// execute state, which waits while the result slot is full and not being read; no new command
// is taken until the last one executes, and every cell of the chain shifts in the same execute cycle
// reset: rst_n clears the entry count and the handshake state; stored words are
// not cleared and only entries below the count are ever returned
module indexed_insert_erase_list #(
    parameter int CAPACITY = ilist_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command beats in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ilist_pkg::S_DATA_W-1:0] s_tdata,  // command[2:0], position[7:3], value[39:8]
    // result beats out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ilist_pkg::M_DATA_W-1:0] m_tdata   // read_value[31:0], count[36:32],
                                                    // status[38:37], zero[39]
);
    import ilist_pkg::*;

    ctrl_t            ctrl;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] count;
    logic [ST_W-1:0]  status;

    // handshake sequencing: capture a beat, then execute once the result slot is free
    ilist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    // cell chain, count and result registers
    ilist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .command    (s_tdata[CMD_W-1:0]),
        .position   (s_tdata[CMD_W+POS_W-1:CMD_W]),
        .value      (s_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W]),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

    // pack the result beat, lowest field first, pad to whole bytes
    assign m_tdata = {{(M_DATA_W - VAL_W - CNT_W - ST_W){1'b0}}, status, count, read_value};

endmodule
